/* sv/pwd_pkg.sv */
// ----------------------------------------------------------------------------
// pwd_pkg
// Shared constants, codes and types for the pulse window detector.
// ----------------------------------------------------------------------------
package pwd_pkg;

    // default build values
    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_MARGIN      = 100;
    localparam int DEF_LOOKBACK    = 5;
    localparam int DEF_LOOKAHEAD   = 10;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_PERIOD    = 2'd1;
    localparam logic [1:0] CFG_START     = 2'd2;

    // register reset values
    localparam logic [15:0] RST_THRESHOLD = 16'd16384;
    localparam logic [31:0] RST_PERIOD    = 32'd1;
    localparam logic [30:0] RST_START     = 31'd1;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_COUNT  = 2'd1;
    localparam logic [1:0] ST_PERIOD = 2'd2;

    // per-waveform summary flags handed from the tracker
    typedef struct packed {
        logic [1:0] status;
        logic       found;
    } t_flags;

endpackage

/* sv/pulse_window_detector.sv */
// ----------------------------------------------------------------------------
// pulse_window_detector
// Finds the first pulse in a sampled waveform with a hysteresis threshold and
// reports its bounds, times and a suggested capture window on the last item.
// ----------------------------------------------------------------------------
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+---------------------------
// in       | input     | i_in_valid / o_in_stall | i_sample, i_last
// out      | output    | o_out_valid/i_out_stall | o_found .. o_status
// cfg      | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained, but a waveform's last item waits while the
// summary register cannot load; an item passes an input register, the pulse
// tracker with its summary register, and the output register holding the
// two index-by-period products. Reset (synchronous, active low) clears all
// waveform state and loads the register defaults. Stalls back up stage by
// stage; only a last item waits on a held summary, others keep flowing.
// ----------------------------------------------------------------------------
module pulse_window_detector import pwd_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MARGIN      = DEF_MARGIN,
    parameter int LOOKBACK    = DEF_LOOKBACK,
    parameter int LOOKAHEAD   = DEF_LOOKAHEAD,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [15:0]                   o_start_index,
    output logic [15:0]                   o_end_index,
    output logic [47:0]                   o_start_ts,
    output logic [47:0]                   o_end_ts,
    output logic [31:0]                   o_new_window_start,
    output logic [31:0]                   o_new_window_size,
    output logic [1:0]                    o_status,
    // register writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 2);
    localparam int PROD_W = IDX_W + 32;

    // configuration registers
    logic [15:0] r_threshold;
    logic [31:0] r_period;
    logic [30:0] r_data_start;

    // input stage
    logic                          r_s0_valid;
    logic signed [SAMPLE_BITS-1:0] r_s0_sample;
    logic                          r_s0_last;

    // summary stage
    logic             r_s2_valid;
    t_flags           r_s2_flags;
    logic [IDX_W-1:0] r_s2_start;
    logic [IDX_W-1:0] r_s2_end;
    logic [CNT_W-1:0] r_s2_count;

    // output stage
    logic        r_o_valid;
    logic        r_o_found;
    logic [15:0] r_o_start_index;
    logic [15:0] r_o_end_index;
    logic [47:0] r_o_start_ts;
    logic [47:0] r_o_end_ts;
    logic [31:0] r_o_ws;
    logic [31:0] r_o_wsize;
    logic [1:0]  r_o_status;

    logic             out_free;
    logic             s2_ready;
    logic             consume;
    logic             s0_ready;
    t_flags           trk_flags;
    logic [IDX_W-1:0] trk_start;
    logic [IDX_W-1:0] trk_end;
    logic [CNT_W-1:0] trk_count;

    logic [PROD_W-1:0]  prod_s;
    logic [PROD_W-1:0]  prod_e;
    logic [63:0]        prod_s64;
    logic [63:0]        prod_e64;
    logic signed [33:0] ns;
    logic signed [33:0] win;
    logic [31:0]        s_idx32;
    logic [31:0]        e_idx32;

    // stage flow control
    assign out_free   = !r_o_valid || !i_out_stall;
    assign s2_ready   = !r_s2_valid || out_free;
    assign consume    = r_s0_valid && (!r_s0_last || s2_ready);
    assign s0_ready   = !r_s0_valid || consume;
    assign o_in_stall = !s0_ready;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= RST_THRESHOLD;
            r_period     <= RST_PERIOD;
            r_data_start <= RST_START;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_threshold  <= i_cfg_data[15:0];
                CFG_PERIOD:    r_period     <= i_cfg_data;
                CFG_START:     r_data_start <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s0_ready && i_in_valid) begin
            r_s0_sample <= i_sample;
            r_s0_last   <= i_last;
        end
    end

    // pulse tracking
    pwd_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_SAMPLES (MAX_SAMPLES),
        .LOOKBACK    (LOOKBACK),
        .LOOKAHEAD   (LOOKAHEAD)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (consume),
        .i_sample      (r_s0_sample),
        .i_last        (r_s0_last),
        .i_threshold   (r_threshold),
        .i_period_zero (r_period == '0),
        .o_flags       (trk_flags),
        .o_start_idx   (trk_start),
        .o_end_idx     (trk_end),
        .o_count       (trk_count)
    );

    // summary register, loaded on the final item of a waveform
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= consume && r_s0_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && consume && r_s0_last) begin
            r_s2_flags <= trk_flags;
            r_s2_start <= trk_start;
            r_s2_end   <= trk_end;
            r_s2_count <= trk_count;
        end
    end

    // times and suggested window
    always_comb begin
        prod_s   = PROD_W'(r_s2_start) * PROD_W'(r_period);
        prod_e   = PROD_W'(r_s2_end) * PROD_W'(r_period);
        prod_s64 = 64'(prod_s);
        prod_e64 = 64'(prod_e);
        s_idx32  = 32'(r_s2_start);
        e_idx32  = 32'(r_s2_end);

        ns = 34'(r_data_start) + 34'(r_s2_start) - 34'(MARGIN);
        if (ns < 34'sd1) begin
            ns = 34'sd1;
        end
        win = 34'(r_data_start) + 34'(r_s2_end) - ns + 34'(MARGIN + 1);
        if (win < 34'sd1) begin
            win = 34'sd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_o_status <= r_s2_flags.status;
            r_o_found  <= r_s2_flags.found;
            if (r_s2_flags.found) begin
                r_o_start_index <= s_idx32[15:0];
                r_o_end_index   <= e_idx32[15:0];
                r_o_start_ts    <= prod_s64[47:0];
                r_o_end_ts      <= prod_e64[47:0];
                r_o_ws          <= ns[31:0];
                r_o_wsize       <= win[31:0];
            end else begin
                r_o_start_index <= '0;
                r_o_end_index   <= '0;
                r_o_start_ts    <= '0;
                r_o_end_ts      <= '0;
                r_o_ws          <= 32'(r_data_start);
                r_o_wsize       <= 32'(r_s2_count);
            end
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_found            = r_o_found;
    assign o_start_index      = r_o_start_index;
    assign o_end_index        = r_o_end_index;
    assign o_start_ts         = r_o_start_ts;
    assign o_end_ts           = r_o_end_ts;
    assign o_new_window_start = r_o_ws;
    assign o_new_window_size  = r_o_wsize;
    assign o_status           = r_o_status;

    // a found pulse always carries ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_found |-> r_o_status == ST_OK)
        else $error("found result with bad status");

    // pulse end never precedes its start
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_s2_flags.found |-> r_s2_start <= r_s2_end)
        else $error("pulse end before start");

    // a waiting summary holds while the output is stalled
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_o_valid && i_out_stall |=> r_s2_valid && $stable(r_s2_start))
        else $error("summary lost under stall");

    // a found pulse yields a nonempty window
    a_win: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_found |-> r_o_wsize != '0)
        else $error("empty suggested window");

endmodule

/* sv/pwd_track.sv */
// ----------------------------------------------------------------------------
// pwd_track
// Per-waveform pulse tracking: magnitude history, start look-back, end
// candidate with confirmation countdown, and the end-of-waveform summary.
// ----------------------------------------------------------------------------
module pwd_track import pwd_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int LOOKBACK    = DEF_LOOKBACK,
    parameter int LOOKAHEAD   = DEF_LOOKAHEAD,
    localparam int IDX_W      = $clog2(MAX_SAMPLES),
    localparam int CNT_W      = $clog2(MAX_SAMPLES + 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_last,
    input  logic [15:0]                   i_threshold,
    input  logic                          i_period_zero,
    output t_flags                        o_flags,
    output logic [IDX_W-1:0]              o_start_idx,
    output logic [IDX_W-1:0]              o_end_idx,
    output logic [CNT_W-1:0]              o_count
);

    localparam int CMP_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
    localparam int CD_W  = $clog2(LOOKAHEAD);
    localparam int LB_W  = $clog2(LOOKBACK + 1);

    logic [SAMPLE_BITS-1:0] r_hist [LOOKBACK];
    logic [SAMPLE_BITS-1:0] n_hist [LOOKBACK];
    logic [CNT_W-1:0]       r_count,     n_count;
    logic                   r_in_pulse,  n_in_pulse;
    logic [IDX_W-1:0]       r_start,     n_start;
    logic                   r_have_start, n_have_start;
    logic [IDX_W-1:0]       r_end,       n_end;
    logic                   r_have_end,  n_have_end;
    logic [CD_W-1:0]        r_cd,        n_cd;
    logic                   r_done,      n_done;
    logic [IDX_W-1:0]       r_last_low,  n_last_low;

    logic [SAMPLE_BITS-1:0] mag;
    logic [CMP_W-1:0]       thr_ext;
    logic                   above;
    logic                   low;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [LOOKBACK-1:0]    hist_low;
    logic                   look_hit;
    logic [LB_W-1:0]        look_j;

    // magnitude and threshold compares
    always_comb begin
        mag     = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : SAMPLE_BITS'(i_sample);
        thr_ext = CMP_W'(i_threshold);
        above   = CMP_W'(mag) > thr_ext;
        low     = CMP_W'({mag, 1'b0}) < thr_ext;
        for (int j = 0; j < LOOKBACK; j++) begin
            hist_low[j] = CMP_W'({r_hist[j], 1'b0}) < thr_ext;
        end
    end

    // nearest below-half sample in the history, newest first
    always_comb begin
        look_hit = 1'b0;
        look_j   = '0;
        for (int j = LOOKBACK - 1; j >= 0; j--) begin
            if (hist_low[j]) begin
                look_hit = 1'b1;
                look_j   = LB_W'(j);
            end
        end
    end

    assign in_range = r_count < CNT_W'(MAX_SAMPLES);
    assign idx      = r_count[IDX_W-1:0];

    // next state, summary, and clear on the final sample
    always_comb begin
        n_hist       = r_hist;
        n_count      = r_count;
        n_in_pulse   = r_in_pulse;
        n_start      = r_start;
        n_have_start = r_have_start;
        n_end        = r_end;
        n_have_end   = r_have_end;
        n_cd         = r_cd;
        n_done       = r_done;
        n_last_low   = r_last_low;

        if (i_step && in_range) begin
            if (!r_done) begin
                if (r_cd != '0) begin
                    if (above) begin
                        n_cd  = '0;
                        n_end = r_last_low;
                    end else begin
                        if (low) begin
                            n_last_low = idx;
                        end
                        n_cd = r_cd - 1'b1;
                        if (r_cd == CD_W'(1)) begin
                            n_done = 1'b1;
                        end
                    end
                end else if (r_in_pulse) begin
                    if (low) begin
                        n_end      = idx;
                        n_last_low = idx;
                        n_have_end = 1'b1;
                        n_cd       = CD_W'(LOOKAHEAD - 1);
                    end
                end else if (above) begin
                    n_in_pulse   = 1'b1;
                    n_have_start = 1'b1;
                    n_start      = idx;
                    if (r_count > CNT_W'(LOOKBACK) && look_hit) begin
                        n_start = idx - IDX_W'(look_j);
                    end
                end
            end
            // history shift
            for (int k = LOOKBACK - 1; k > 0; k--) begin
                n_hist[k] = r_hist[k-1];
            end
            n_hist[0] = mag;
        end

        if (i_step && r_count <= CNT_W'(MAX_SAMPLES)) begin
            n_count = r_count + 1'b1;
        end

        // summary as seen after this item
        o_count = n_count;
        if (n_count > CNT_W'(MAX_SAMPLES)) begin
            o_flags.status = ST_COUNT;
        end else if (i_period_zero) begin
            o_flags.status = ST_PERIOD;
        end else begin
            o_flags.status = ST_OK;
        end
        o_flags.found = (o_flags.status == ST_OK) && n_have_start;
        o_start_idx   = n_start;
        o_end_idx     = n_have_end ? n_end : IDX_W'(n_count - 1'b1);

        // waveform done: start fresh
        if (i_step && i_last) begin
            for (int k = 0; k < LOOKBACK; k++) begin
                n_hist[k] = '0;
            end
            n_count      = '0;
            n_in_pulse   = 1'b0;
            n_start      = '0;
            n_have_start = 1'b0;
            n_end        = '0;
            n_have_end   = 1'b0;
            n_cd         = '0;
            n_done       = 1'b0;
            n_last_low   = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LOOKBACK; k++) begin
                r_hist[k] <= '0;
            end
            r_count      <= '0;
            r_in_pulse   <= 1'b0;
            r_start      <= '0;
            r_have_start <= 1'b0;
            r_end        <= '0;
            r_have_end   <= 1'b0;
            r_cd         <= '0;
            r_done       <= 1'b0;
            r_last_low   <= '0;
        end else begin
            r_hist       <= n_hist;
            r_count      <= n_count;
            r_in_pulse   <= n_in_pulse;
            r_start      <= n_start;
            r_have_start <= n_have_start;
            r_end        <= n_end;
            r_have_end   <= n_have_end;
            r_cd         <= n_cd;
            r_done       <= n_done;
            r_last_low   <= n_last_low;
        end
    end

endmodule

/* bench/pulse_window_detector_tb.sv */
// ----------------------------------------------------------------------------
// pulse_window_detector_tb
// Self-checking bench for the pulse window detector. Waveforms are queued as
// sample items, driven with random gaps against a randomly stalling result
// side, and every accepted item runs through a local pulse tracker that
// predicts the end-of-waveform report. Reports are checked field by field in
// order. Register settings change between groups of waveforms.
// ----------------------------------------------------------------------------
module pulse_window_detector_tb;
    import pwd_pkg::*;

    localparam int MAX_SAMPLES     = DEF_MAX_SAMPLES;
    localparam int MARGIN          = DEF_MARGIN;
    localparam int LOOKBACK        = DEF_LOOKBACK;
    localparam int LOOKAHEAD       = DEF_LOOKAHEAD;
    localparam int ITEMS_PER_PHASE = 465;

    typedef enum int {MAG_LOW, MAG_MID, MAG_HIGH} t_mag_class;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } t_sample_item;

    typedef struct {
        logic        found;
        logic [15:0] start_index;
        logic [15:0] end_index;
        logic [47:0] start_ts;
        logic [47:0] end_ts;
        logic [31:0] new_window_start;
        logic [31:0] new_window_size;
        logic [1:0]  status;
    } t_pulse_report;

    // dut signals
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_sample    = '0;
    logic               i_last      = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_found;
    logic [15:0]        o_start_index;
    logic [15:0]        o_end_index;
    logic [47:0]        o_start_ts;
    logic [47:0]        o_end_ts;
    logic [31:0]        o_new_window_start;
    logic [31:0]        o_new_window_size;
    logic [1:0]         o_status;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data  = '0;

    // register copies used by the tracker
    int                 cfg_threshold = RST_THRESHOLD;
    longint unsigned    cfg_period    = RST_PERIOD;
    longint             cfg_start     = RST_START;

    // per-waveform tracker state
    int                 mag_hist[LOOKBACK];
    int unsigned        wave_count;
    bit                 in_pulse;
    bit                 have_start;
    bit                 have_end;
    bit                 pulse_closed;
    int unsigned        pulse_first;
    int unsigned        end_mark;
    int unsigned        latest_low;
    int unsigned        confirm_left;

    t_sample_item       pending_items[$];
    t_pulse_report      expected_reports[$];
    logic signed [15:0] wave_buf[$];

    int                 errors        = 0;
    int                 items_taken   = 0;
    int                 items_queued  = 0;
    int                 reports_seen  = 0;
    int                 n_found       = 0;
    int                 n_overflow    = 0;
    int                 n_no_period   = 0;
    int                 gap_pct       = 0;
    int                 stall_pct     = 0;
    bit                 item_taken    = 1'b0;

    always #2 i_clk = ~i_clk;

    pulse_window_detector uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample           (i_sample),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_found            (o_found),
        .o_start_index      (o_start_index),
        .o_end_index        (o_end_index),
        .o_start_ts         (o_start_ts),
        .o_end_ts           (o_end_ts),
        .o_new_window_start (o_new_window_start),
        .o_new_window_size  (o_new_window_size),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // clear everything kept for one waveform
    function automatic void clear_waveform();
        foreach (mag_hist[k]) mag_hist[k] = 0;
        wave_count   = 0;
        in_pulse     = 1'b0;
        have_start   = 1'b0;
        have_end     = 1'b0;
        pulse_closed = 1'b0;
        pulse_first  = 0;
        end_mark     = 0;
        latest_low   = 0;
        confirm_left = 0;
    endfunction

    // advance the pulse tracker by one item, queue a report on the last one
    function automatic void track_sample(t_sample_item it);
        int              mag;
        int unsigned     idx;
        bit              above;
        bit              low;
        longint unsigned s;
        longint unsigned e;
        longint          ns;
        longint          win;
        t_pulse_report   r;

        mag = it.sample;
        if (mag < 0) mag = -mag;
        idx = wave_count;
        if (idx < MAX_SAMPLES) begin
            above = mag > cfg_threshold;
            low   = 2 * mag < cfg_threshold;
            if (!pulse_closed) begin
                if (confirm_left != 0) begin
                    // a candidate end waits for quiet samples
                    if (above) begin
                        confirm_left = 0;
                        end_mark     = latest_low;
                    end else begin
                        if (low) latest_low = idx;
                        confirm_left--;
                        if (confirm_left == 0) pulse_closed = 1'b1;
                    end
                end else if (in_pulse) begin
                    if (low) begin
                        end_mark     = idx;
                        latest_low   = idx;
                        have_end     = 1'b1;
                        confirm_left = LOOKAHEAD - 1;
                    end
                end else if (above) begin
                    // first crossing, look back for the nearest quiet sample
                    in_pulse    = 1'b1;
                    have_start  = 1'b1;
                    pulse_first = idx;
                    if (idx > LOOKBACK) begin
                        for (int j = 0; j < LOOKBACK; j++) begin
                            if (2 * mag_hist[j] < cfg_threshold) begin
                                pulse_first = idx - j;
                                break;
                            end
                        end
                    end
                end
            end
            for (int k = LOOKBACK - 1; k > 0; k--) mag_hist[k] = mag_hist[k - 1];
            mag_hist[0] = mag;
        end
        if (wave_count <= MAX_SAMPLES) wave_count++;
        if (!it.last) return;

        // end of waveform report
        r.found            = 1'b0;
        r.start_index      = '0;
        r.end_index        = '0;
        r.start_ts         = '0;
        r.end_ts           = '0;
        r.new_window_start = 32'(cfg_start);
        r.new_window_size  = 32'(wave_count);
        r.status           = ST_OK;
        if (wave_count > MAX_SAMPLES) begin
            r.status = ST_COUNT;
            n_overflow++;
        end else if (cfg_period == 0) begin
            r.status = ST_PERIOD;
            n_no_period++;
        end else if (have_start) begin
            s  = pulse_first;
            e  = have_end ? end_mark : wave_count - 1;
            ns = cfg_start + longint'(s) - MARGIN;
            if (ns < 1) ns = 1;
            win = cfg_start + longint'(e) - ns + 1 + MARGIN;
            if (win < 1) win = 1;
            r.found            = 1'b1;
            r.start_index      = s[15:0];
            r.end_index        = e[15:0];
            r.start_ts         = 48'(s * cfg_period);
            r.end_ts           = 48'(e * cfg_period);
            r.new_window_start = ns[31:0];
            r.new_window_size  = win[31:0];
            n_found++;
        end
        expected_reports.push_back(r);
        clear_waveform();
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // sample a magnitude class against the current threshold, random sign
    function automatic logic signed [15:0] draw_sample(t_mag_class c);
        int                 lo;
        int                 hi;
        int                 m;
        logic signed [15:0] v;

        case (c)
            MAG_LOW: begin
                lo = 0;
                hi = (cfg_threshold > 0) ? (cfg_threshold - 1) / 2 : 0;
            end
            MAG_MID: begin
                lo = (cfg_threshold + 1) / 2;
                hi = (cfg_threshold > 32768) ? 32768 : cfg_threshold;
            end
            default: begin
                lo = (cfg_threshold >= 32768) ? 32768 : cfg_threshold + 1;
                hi = 32768;
            end
        endcase
        case ($urandom_range(7, 0))
            0:       m = lo;
            1:       m = hi;
            default: m = $urandom_range(hi, lo);
        endcase
        v = 16'(m);
        if (m != 32768 && $urandom_range(1, 0) == 1) v = -v;
        return v;
    endfunction

    // move the built waveform into the item queue
    task automatic flush_wave(bit ends);
        t_sample_item it;
        foreach (wave_buf[k]) begin
            it.sample = wave_buf[k];
            it.last   = ends && (k == wave_buf.size() - 1);
            pending_items.push_back(it);
        end
        items_queued += wave_buf.size();
        wave_buf.delete();
    endtask

    // quiet lead, optional ramp, peak, then a tail that may bounce
    task automatic push_pulse_wave();
        int lead;
        int rise;
        int peak;
        int tail;
        int r;

        lead = $urandom_range(12, 0);
        rise = $urandom_range(5, 0);
        peak = $urandom_range(8, 1);
        tail = $urandom_range(24, 0);
        repeat (lead)
            wave_buf.push_back(draw_sample($urandom_range(2, 0) == 0 ? MAG_MID : MAG_LOW));
        repeat (rise) wave_buf.push_back(draw_sample(MAG_MID));
        repeat (peak)
            wave_buf.push_back(draw_sample($urandom_range(5, 0) == 0 ? MAG_MID : MAG_HIGH));
        repeat (tail) begin
            r = $urandom_range(9, 0);
            wave_buf.push_back(draw_sample(r == 0 ? MAG_HIGH : (r < 3 ? MAG_MID : MAG_LOW)));
        end
        flush_wave(1'b1);
    endtask

    task automatic push_other_wave(bit noisy);
        repeat ($urandom_range(20, 1)) begin
            if (noisy) wave_buf.push_back(16'($urandom));
            else wave_buf.push_back(draw_sample($urandom_range(3, 0) == 0 ? MAG_MID : MAG_LOW));
        end
        flush_wave(1'b1);
    endtask

    task automatic push_values(int vals[], bit ends);
        foreach (vals[k]) wave_buf.push_back(16'(vals[k]));
        flush_wave(ends);
    endtask

    // hold until every queued item is taken and every report has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_THRESHOLD: cfg_threshold = data[15:0];
            CFG_PERIOD:    cfg_period    = data;
            CFG_START:     cfg_start     = data[30:0];
            default:       ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // new random settings, extremes now and then
    task automatic random_settings();
        int          thr_picks[6] = '{0, 1, 2, 32767, 32768, 65535};
        logic [15:0] thr;
        logic [31:0] per;
        logic [30:0] st;

        if ($urandom_range(4, 0) == 0) thr = 16'(thr_picks[$urandom_range(5, 0)]);
        else thr = 16'($urandom_range(30000, 40));
        case ($urandom_range(5, 0))
            0:       per = 32'd0;
            1:       per = 32'hFFFF_FFFF;
            2:       per = 32'd1;
            default: per = $urandom;
        endcase
        case ($urandom_range(3, 0))
            0:       st = 31'd1;
            1:       st = 31'h7FFF_FFFF;
            2:       st = 31'($urandom_range(150, 0));
            default: st = 31'($urandom);
        endcase
        set_reg(CFG_THRESHOLD, {16'($urandom), thr});
        set_reg(CFG_PERIOD, per);
        set_reg(CFG_START, {1'($urandom), st});
    endtask

    // accept items into the tracker and check reports
    always @(posedge i_clk) begin
        t_pulse_report want;
        item_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (item_taken) begin
            track_sample(pending_items.pop_front());
            items_taken++;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("report with no waveform end pending");
                errors++;
            end else begin
                want = expected_reports.pop_front();
                compare_field("found", want.found, o_found);
                compare_field("start_index", want.start_index, o_start_index);
                compare_field("end_index", want.end_index, o_end_index);
                compare_field("start_ts", want.start_ts, o_start_ts);
                compare_field("end_ts", want.end_ts, o_end_ts);
                compare_field("new_window_start", want.new_window_start, o_new_window_start);
                compare_field("new_window_size", want.new_window_size, o_new_window_size);
                compare_field("status", want.status, o_status);
            end
        end
    end

    // item driver and result-side stalls
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !item_taken)) begin
            if (pending_items.size() == 0 || $urandom_range(99, 0) < gap_pct) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_sample   <= pending_items[0].sample;
                i_last     <= pending_items[0].last;
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    initial begin
        int pushed;
        int waves;
        int pick;

        clear_waveform();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale single sample, early start with open end
        gap_pct   = 32;
        stall_pct = 67;
        push_values('{-32768}, 1'b1);
        push_values('{100, 32767, -5, 7}, 1'b1);

        // zero period, then widest settings with an unreachable threshold
        wait_drained();
        set_reg(CFG_PERIOD, 32'd0);
        push_values('{20000}, 1'b1);
        wait_drained();
        set_reg(CFG_PERIOD, 32'hFFFF_FFFF);
        set_reg(CFG_START, 32'hFFFF_FFFF);
        set_reg(CFG_THRESHOLD, {16'hA5A5, 16'd32768});
        push_values('{-32768, 32767}, 1'b1);

        // look-back, failed candidate, then confirmation; sender pauses midway
        wait_drained();
        set_reg(CFG_THRESHOLD, 32'd1000);
        set_reg(CFG_PERIOD, 32'd7);
        set_reg(CFG_START, 32'd60);
        push_values('{0, 0, 0, 0, 0, 0, 700, -800, 1500, 1200, 100, 300, -1001}, 1'b0);
        wait_drained();
        push_values('{0, 400, 600, -1000, 20, -20, 499, -499, 500, 0}, 1'b1);

        // random waveforms under three idling patterns
        for (int ph = 0; ph < 3; ph++) begin
            gap_pct   = (ph == 0) ? 32 : ((ph == 1) ? 67 : 0);
            stall_pct = (ph == 0) ? 67 : ((ph == 1) ? 32 : 0);
            pushed    = items_queued;
            waves     = 0;
            while (items_queued - pushed < ITEMS_PER_PHASE) begin
                if (waves % 6 == 0) begin
                    wait_drained();
                    random_settings();
                end
                pick = $urandom_range(9, 0);
                if (pick < 7) push_pulse_wave();
                else push_other_wave(pick == 9);
                waves++;
            end
        end

        wait_drained();
        $display("covered %0d items in %0d waveform reports", items_taken, reports_seen);
        $display("reports with a pulse %0d, count overflow %0d, zero period %0d",
                 n_found, n_overflow, n_no_period);
        if (errors == 0 && expected_reports.size() == 0)
            $display("pulse_window_detector regression: pass");
        else
            $display("pulse_window_detector regression: fail");
        $finish;
    end

    // watchdog
    initial begin
        #12000000;
        $display("pulse_window_detector regression: fail");
        $finish;
    end

endmodule

/* pulse_window_detector.f */
sv/pwd_pkg.sv
sv/pwd_track.sv
sv/pulse_window_detector.sv
bench/pulse_window_detector_tb.sv
